>>> rtl/core/wrsp_pkg.sv
// Package for the WAV sample parser: payload structs, status codes, chunk ids and
// the PCM16-to-float conversion. It has no dependencies.
`default_nettype none
package wrsp_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] sample_bits;
    logic [15:0] channel_index;
    logic [3:0]  status;
    logic [31:0] rate_hz;
    logic [15:0] channel_count;
    logic [15:0] sample_width;
    logic [31:0] frame_count;
    logic        last;
  } out_item_t;

  // One classified byte handed from the front part to the back part.
  typedef struct packed {
    logic        has_sample;
    logic [31:0] sample_bits;
    logic [15:0] channel_index;
    logic        has_status;
    logic [3:0]  status;
    logic [31:0] rate_hz;
    logic [15:0] channel_count;
    logic [15:0] sample_width;
    logic [31:0] frame_count;
  } work_t;

  localparam logic [3:0] StOk        = 4'd0;
  localparam logic [3:0] StShort     = 4'd1;
  localparam logic [3:0] StNotWave   = 4'd2;
  localparam logic [3:0] StTrunc     = 4'd3;
  localparam logic [3:0] StFmtSmall  = 4'd4;
  localparam logic [3:0] StMissing   = 4'd5;
  localparam logic [3:0] StBadBits   = 4'd6;
  localparam logic [3:0] StBadFormat = 4'd7;
  localparam logic [3:0] StUnsupp    = 4'd8;
  localparam logic [3:0] StDataFirst = 4'd9;

  localparam logic [31:0] IdRiff = 32'h4646_4952;
  localparam logic [31:0] IdWave = 32'h4556_4157;
  localparam logic [31:0] IdFmt  = 32'h2074_6D66;
  localparam logic [31:0] IdData = 32'h6174_6164;
  localparam logic [31:0] MinFileBytes = 32'd44;
  localparam logic [31:0] MinFmtBytes  = 32'd16;

  localparam int unsigned QueueDepthDef = 4;

  // Exact conversion of a signed 16-bit sample divided by 32768 to float32.
  function automatic logic [31:0] pcm16_to_float(input logic [15:0] raw);
    logic [15:0] mag;
    logic [4:0]  msb;
    logic [15:0] norm;
    logic [7:0]  expo;
    mag  = raw[15] ? (~raw + 16'd1) : raw;
    msb  = 5'd0;
    for (int i = 0; i < 16; i++) begin
      if (mag[i]) msb = 5'(i);
    end
    norm = mag << (5'd15 - msb);
    expo = 8'd112 + {3'd0, msb};
    if (mag == 16'd0) begin
      return 32'd0;
    end
    return {raw[15], expo, norm[14:0], 8'd0};
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/wav_riff_sample_parser_unit.sv
// Top level of the WAV RIFF sample parser: front byte walker and back result queue.
// Depends on wrsp_pkg, wrsp_front and wrsp_back.
`default_nettype none
// Usage:
// The input channel is a queue write port: drive one file byte on in_i with push
// high; it is taken at a clock edge where full is low. Mark the final byte of a
// file with end_of_file. Results leave through a queue read port: while empty is
// low the oldest result is on out_o, and it is taken when pop is high.
// The front walker accepts one byte per cycle while full is low.
// A completed sample is registered in the work queue as its last byte is accepted.
// The final byte yields a status result (after its sample, if any), flagged last.
// Samples are streamed before the end check; on a nonzero status the receiver
// drops the samples of that file. When the receiver stalls, results wait in a
// small work queue; full is high while the queue holds QueueDepth-1 entries and
// none retires in that cycle, so no byte is lost.
// A byte carrying both a sample and a status takes two pops to drain.
// Reset clears the walker to the start of a file and empties the queue; after
// each final byte the walker returns to that same state for the next file.
module wav_riff_sample_parser_unit #(
  parameter int unsigned QueueDepth = wrsp_pkg::QueueDepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire wrsp_pkg::in_item_t in_i,
  output logic                    empty,
  input  wire logic               pop,
  output wrsp_pkg::out_item_t     out_o
);

  logic            room, wvalid, ready;
  wrsp_pkg::work_t work;

  wrsp_front u_front (
    .clk_i, .rst_ni, .valid_i(push), .item_i(in_i), .room_i(room),
    .ready_o(ready), .wvalid_o(wvalid), .work_o(work)
  );

  wrsp_back #(.Depth(QueueDepth)) u_back (
    .clk_i, .rst_ni, .wvalid_i(wvalid), .work_i(work), .room_o(room),
    .empty_o(empty), .pop_i(pop), .item_o(out_o)
  );

  assign full = !ready;

endmodule
`default_nettype wire

>>> rtl/core/wrsp_front.sv
// Front part of the WAV parser: walks the RIFF header and chunks one byte per cycle
// while room_i is high and classifies each byte into a work entry. Uses wrsp_pkg.
`default_nettype none
module wrsp_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire wrsp_pkg::in_item_t item_i,
  input  wire logic               room_i,
  output logic                    ready_o,
  output logic                    wvalid_o,
  output wrsp_pkg::work_t         work_o
);

  typedef enum logic [4:0] {
    PhHeader = 5'b00001,
    PhHdr    = 5'b00010,
    PhBody   = 5'b00100,
    PhPad    = 5'b01000,
    PhHalt   = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    BodySkip = 2'd0,
    BodyFmt  = 2'd1,
    BodyData = 2'd2
  } body_e;

  phase_e      phase_q, phase_d;
  body_e       body_q, body_d;
  logic [31:0] pos_q, pos_d;
  logic [63:0] hdr_q, hdr_d;
  logic [31:0] left_q, left_d;
  logic [2:0]  hcnt_q, hcnt_d;
  logic        riff_ok_q, riff_ok_d;
  logic [15:0] fmt_code_q, fmt_code_d, chans_q, chans_d, width_q, width_d;
  logic [31:0] rate_q, rate_d;
  logic        fmt_found_q, fmt_found_d, data_found_q, data_found_d;
  logic [31:0] asm_q, asm_d;
  logic [1:0]  sbc_q, sbc_d;
  logic [15:0] chan_q, chan_d;
  logic [2:0]  sbytes_q, sbytes_d;
  logic [31:0] data_size_q, data_size_d;
  logic [31:0] frames_seen_q, frames_seen_d;
  // Running count of data bytes left for whole frames replaces the frame-total divide.
  logic [31:0] fbytes_left_q, fbytes_left_d;
  logic [3:0]  err_q, err_d;

  logic            take;
  logic [7:0]      b;
  logic [63:0]     hdr_sh;
  logic [31:0]     sz, off;
  wrsp_pkg::work_t w;

  assign ready_o  = room_i;
  assign take     = valid_i && room_i;
  assign b        = item_i.byte_value;
  assign hdr_sh   = {b, hdr_q[63:8]};
  assign sz       = hdr_q[63:32];
  assign off      = sz - left_q;
  assign wvalid_o = take;
  assign work_o   = w;

  always_comb begin
    logic [31:0] fb;
    logic [31:0] bps;
    logic [3:0]  st;
    logic [31:0] frames;
    logic [2:0]  nsb;
    logic [15:0] chn;
    logic [31:0] szn;
    logic [31:0] fbw;
    logic        whole;
    phase_d = phase_q; body_d = body_q; pos_d = pos_q; hdr_d = hdr_q; left_d = left_q;
    hcnt_d = hcnt_q; riff_ok_d = riff_ok_q; fmt_code_d = fmt_code_q; chans_d = chans_q;
    width_d = width_q; rate_d = rate_q; fmt_found_d = fmt_found_q;
    data_found_d = data_found_q; asm_d = asm_q; sbc_d = sbc_q; chan_d = chan_q;
    sbytes_d = sbytes_q; data_size_d = data_size_q; frames_seen_d = frames_seen_q;
    fbytes_left_d = fbytes_left_q; err_d = err_q;
    w = '0;
    fb = '0; bps = '0; st = wrsp_pkg::StOk; frames = '0; nsb = '0; chn = '0;
    szn = '0; fbw = '0; whole = 1'b0;
    if (take) begin
      if (pos_q != 32'hFFFF_FFFF) pos_d = pos_q + 32'd1;
      unique case (phase_q)
        PhHeader: begin
          hdr_d = hdr_sh;
          if (pos_q == 32'd7) riff_ok_d = (hdr_sh[31:0] == wrsp_pkg::IdRiff);
          if (pos_q == 32'd11) begin
            if (!riff_ok_q || hdr_sh[63:32] != wrsp_pkg::IdWave) begin
              err_d = wrsp_pkg::StNotWave; phase_d = PhHalt;
            end else begin
              phase_d = PhHdr; hcnt_d = '0;
            end
          end
        end
        PhHdr: begin
          hdr_d  = hdr_sh;
          hcnt_d = hcnt_q + 3'd1;
          if (hcnt_q == 3'd7) begin
            szn    = hdr_sh[63:32];
            body_d = BodySkip;
            left_d = szn;
            phase_d = PhBody;
            if (hdr_sh[31:0] == wrsp_pkg::IdFmt) begin
              body_d = BodyFmt;
              if (!data_found_q) fmt_found_d = 1'b1;
            end else if (hdr_sh[31:0] == wrsp_pkg::IdData && !data_found_q) begin
              if (!fmt_found_q) begin
                err_d = wrsp_pkg::StDataFirst; phase_d = PhHalt;
              end else begin
                data_found_d = 1'b1; data_size_d = szn; body_d = BodyData;
                nsb = '0;
                if (fmt_code_q == 16'd1 && width_q == 16'd16) nsb = 3'd2;
                if (fmt_code_q == 16'd3 && width_q == 16'd32) nsb = 3'd4;
                sbytes_d = nsb;
                // Frame bytes: channel count times sample bytes; the byte budget starts at size.
                fbw = (nsb == 3'd2) ? {15'd0, chans_q, 1'b0} : {14'd0, chans_q, 2'b0};
                fbytes_left_d = '0;
                if (nsb != 3'd0 && chans_q != 16'd0) begin
                  fbytes_left_d = szn;
                end
                frames_seen_d = '0; chan_d = '0; sbc_d = '0; asm_d = '0;
              end
            end
            if (szn == 32'd0 && phase_d == PhBody) begin
              if (body_d == BodyFmt) begin
                err_d = wrsp_pkg::StFmtSmall; phase_d = PhHalt;
              end else begin
                phase_d = PhHdr; hcnt_d = '0;
              end
            end
          end
        end
        PhBody: begin
          if (body_q == BodyFmt && !data_found_q) begin
            unique case (off)
              32'd0:  fmt_code_d[7:0]  = b;
              32'd1:  fmt_code_d[15:8] = b;
              32'd2:  chans_d[7:0]     = b;
              32'd3:  chans_d[15:8]    = b;
              32'd4:  rate_d[7:0]      = b;
              32'd5:  rate_d[15:8]     = b;
              32'd6:  rate_d[23:16]    = b;
              32'd7:  rate_d[31:24]    = b;
              32'd14: width_d[7:0]     = b;
              32'd15: width_d[15:8]    = b;
              default: ;
            endcase
          end else if (body_q == BodyData) begin
            // Frame bytes remaining in the current frame region are tracked by
            // fbytes_left; a frame only counts if the whole frame fits.
            fbw = (sbytes_q == 3'd2) ? {15'd0, chans_q, 1'b0} : {14'd0, chans_q, 2'b0};
            whole = (fbytes_left_q >= fbw) || (chan_q != 16'd0) || (sbc_q != 2'd0);
            if (sbytes_q != 3'd0 && fbytes_left_q != 32'd0 && whole) begin
              asm_d = {b, asm_q[31:8]};
              if ({1'b0, sbc_q} + 3'd1 < sbytes_q) begin
                sbc_d = sbc_q + 2'd1;
              end else begin
                sbc_d = '0;
                w.has_sample    = 1'b1;
                w.channel_index = chan_q;
                w.sample_bits   = (sbytes_q == 3'd2) ?
                                  wrsp_pkg::pcm16_to_float(asm_d[31:16]) : asm_d;
                chn = chan_q + 16'd1;
                if (chn >= chans_q) begin
                  chan_d = '0;
                  frames_seen_d = frames_seen_q + 32'd1;
                  fbytes_left_d = fbytes_left_q - fbw;
                end else begin
                  chan_d = chn;
                end
              end
            end
          end
          left_d = left_q - 32'd1;
          if (left_q == 32'd1) begin
            if (body_q == BodyFmt && sz < wrsp_pkg::MinFmtBytes) begin
              err_d = wrsp_pkg::StFmtSmall; phase_d = PhHalt;
            end else begin
              phase_d = sz[0] ? PhPad : PhHdr; hcnt_d = '0;
            end
          end
        end
        PhPad: begin
          phase_d = PhHdr; hcnt_d = '0;
        end
        PhHalt: ;
        default: ;
      endcase

      if (item_i.end_of_file) begin
        bps = {16'd0, width_d};
        fb  = {16'd0, chans_d} * {3'd0, bps[31:3]};
        if (pos_d < wrsp_pkg::MinFileBytes) st = wrsp_pkg::StShort;
        else if (err_d != wrsp_pkg::StOk) st = err_d;
        else if (phase_d == PhBody && left_d != 32'd0) st = wrsp_pkg::StTrunc;
        else if (!data_found_d || chans_d == 16'd0) st = wrsp_pkg::StMissing;
        else if (bps == 32'd0 || bps[2:0] != 3'd0) st = wrsp_pkg::StBadBits;
        else if (fmt_code_d != 16'd1 && fmt_code_d != 16'd3) st = wrsp_pkg::StBadFormat;
        else if (fb == 32'd0) st = wrsp_pkg::StBadBits;
        else begin
          // The data chunk is fully walked here, so for a supported layout the
          // frames counted while streaming equal size over frame bytes. Any other
          // layout only needs to know whether at least one frame fits.
          if (data_size_d >= fb) begin
            if ((fmt_code_d == 16'd1 && bps == 32'd16) ||
                (fmt_code_d == 16'd3 && bps == 32'd32)) begin
              frames = frames_seen_d;
              st = wrsp_pkg::StOk;
            end else begin
              st = wrsp_pkg::StUnsupp;
            end
          end
        end
        w.has_status    = 1'b1;
        w.status        = st;
        w.rate_hz       = rate_d;
        w.channel_count = chans_d;
        w.sample_width  = width_d;
        w.frame_count   = frames;
      end
    end
  end

  // The final byte of a file returns the walker to its reset state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader; body_q <= BodySkip; pos_q <= '0; hdr_q <= '0; left_q <= '0;
      hcnt_q <= '0; riff_ok_q <= 1'b0; fmt_code_q <= '0; chans_q <= '0; width_q <= '0;
      rate_q <= '0; fmt_found_q <= 1'b0; data_found_q <= 1'b0; asm_q <= '0;
      sbc_q <= '0; chan_q <= '0; sbytes_q <= '0; data_size_q <= '0;
      frames_seen_q <= '0; fbytes_left_q <= '0; err_q <= '0;
    end else if (take && item_i.end_of_file) begin
      phase_q <= PhHeader; body_q <= BodySkip; pos_q <= '0; hdr_q <= '0; left_q <= '0;
      hcnt_q <= '0; riff_ok_q <= 1'b0; fmt_code_q <= '0; chans_q <= '0; width_q <= '0;
      rate_q <= '0; fmt_found_q <= 1'b0; data_found_q <= 1'b0; asm_q <= '0;
      sbc_q <= '0; chan_q <= '0; sbytes_q <= '0; data_size_q <= '0;
      frames_seen_q <= '0; fbytes_left_q <= '0; err_q <= '0;
    end else begin
      phase_q <= phase_d; body_q <= body_d; pos_q <= pos_d; hdr_q <= hdr_d;
      left_q <= left_d; hcnt_q <= hcnt_d; riff_ok_q <= riff_ok_d;
      fmt_code_q <= fmt_code_d; chans_q <= chans_d; width_q <= width_d;
      rate_q <= rate_d; fmt_found_q <= fmt_found_d; data_found_q <= data_found_d;
      asm_q <= asm_d; sbc_q <= sbc_d; chan_q <= chan_d; sbytes_q <= sbytes_d;
      data_size_q <= data_size_d; frames_seen_q <= frames_seen_d;
      fbytes_left_q <= fbytes_left_d; err_q <= err_d;
    end
  end

`ifndef SYNTHESIS
  a_halt_has_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhHalt |-> err_q != wrsp_pkg::StOk)
    else $error("halted without an error code");
  a_no_work_without_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |-> !wvalid_o)
    else $error("work entry without an accepted byte");
  a_sbc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sbytes_q == 3'd2 |-> sbc_q <= 2'd1)
    else $error("PCM16 byte count out of range");
`endif

endmodule
`default_nettype wire

>>> rtl/core/wrsp_back.sv
// Back part of the WAV parser: a work queue whose head entry drives item_o, which
// splits the entry into its sample and status results. Uses wrsp_pkg.
`default_nettype none
module wrsp_back #(
  parameter int unsigned Depth = wrsp_pkg::QueueDepthDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wvalid_i,
  input  wire wrsp_pkg::work_t work_i,
  output logic                 room_o,
  output logic                 empty_o,
  input  wire logic            pop_i,
  output wrsp_pkg::out_item_t  item_o
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  wrsp_pkg::work_t  mem_q [Depth];
  logic [Aw-1:0]    wr_q, rd_q;
  logic [Aw:0]      cnt_q;
  logic             ent_valid;
  wrsp_pkg::work_t  ent;
  logic             sample_done_q;
  logic             done, wr_en;

  assign room_o    = (cnt_q < (Aw+1)'(Depth - 1)) || (cnt_q == (Aw+1)'(Depth - 1) && done);
  assign wr_en     = wvalid_i && (work_i.has_sample || work_i.has_status);
  assign ent_valid = (cnt_q != '0);
  assign ent       = mem_q[rd_q];

  // Head entry emits its sample first, then its status.
  logic show_sample;
  assign show_sample = ent.has_sample && !sample_done_q;
  assign empty_o     = !ent_valid;
  assign done        = ent_valid && pop_i && (!show_sample || !ent.has_status);

  always_comb begin
    item_o = '0;
    if (show_sample) begin
      item_o.sample_bits   = ent.sample_bits;
      item_o.channel_index = ent.channel_index;
    end else begin
      item_o.kind          = 1'b1;
      item_o.status        = ent.status;
      item_o.rate_hz       = ent.rate_hz;
      item_o.channel_count = ent.channel_count;
      item_o.sample_width  = ent.sample_width;
      item_o.frame_count   = ent.frame_count;
      item_o.last          = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_q] <= work_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0; sample_done_q <= 1'b0;
    end else begin
      if (wr_en) wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + Aw'(1);
      if (done) begin
        rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + Aw'(1);
        sample_done_q <= 1'b0;
      end else if (ent_valid && pop_i) begin
        sample_done_q <= 1'b1;
      end
      cnt_q <= cnt_q + (Aw+1)'(wr_en) - (Aw+1)'(done);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (Aw+1)'(Depth))
    else $error("work queue overflow");
  a_split_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !sample_done_q)
    else $error("split flag kept after entry retired");
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o == (cnt_q == '0))
    else $error("empty disagrees with fill count");
`endif

endmodule
`default_nettype wire
